// ===== sv/ffba_pkg.sv =====
`timescale 1ns / 1ps
package ffba_pkg;

   typedef struct packed {
      logic        opcode;
      logic [19:0] request_size;
      logic [18:0] block_addr;
   } req_type;

   typedef struct packed {
      logic [18:0] granted_addr;
      logic [2:0]  status;
   } rsp_type;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NOTABLE = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_NOMEM   = 3'd3;
   localparam logic [2:0] ST_UNKNOWN = 3'd4;

   localparam int unsigned ALLOC_BASE = 32'h1010;
   localparam int unsigned GRANULE    = 16;

endpackage

// ===== sv/ffba_table.sv =====
`timescale 1ns / 1ps
// record memory: one write port, one registered read port
module ffba_table #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int DW    = 41
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);
   logic [DW-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== sv/first_fit_block_allocator_top.sv =====
`timescale 1ns / 1ps
// First-fit allocator over an address-sorted record table held in one
// single-port-write, registered-read memory. Busy is high from the cycle
// after start is taken until the result strobe. An item scans the table one
// record at a time, in a read state and then a compare state. An allocate
// that splits then shifts the tail up one record. A free that merges shifts
// the tail down once or twice. Each moved record takes a read state and a
// write state. With no table the item goes straight to the done state. The
// slowest item is a free near the head of a full table that merges on both
// sides. The result is shown on rsp_ for exactly one cycle with rsp_valid
// and cannot be stalled. A csr_ write is taken only while idle and rebuilds
// the table as a single free record. A limit of zero means no table.
module first_fit_block_allocator_top #(
   parameter int RAM_BYTES   = 524288,
   parameter int MAX_RECORDS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  ffba_pkg::req_type   req_item,
   output logic                rsp_valid,
   output ffba_pkg::rsp_type   rsp_item,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [6:0]          csr_data
);
   import ffba_pkg::*;

   localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int CW = $clog2(MAX_RECORDS + 1);
   localparam int SW = 21;   // sizes and addresses up to RAM_BYTES
   localparam int DW = 1 + SW + SW;

   // sequencer codes
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RD    = 4'd1;
   localparam logic [3:0] S_CMP   = 4'd2;
   localparam logic [3:0] S_UPRD  = 4'd3;
   localparam logic [3:0] S_UPWR  = 4'd4;
   localparam logic [3:0] S_SPLIT = 4'd5;
   localparam logic [3:0] S_NXRD  = 4'd6;
   localparam logic [3:0] S_NXCK  = 4'd7;
   localparam logic [3:0] S_PVRD  = 4'd8;
   localparam logic [3:0] S_PVCK  = 4'd9;
   localparam logic [3:0] S_DNRD  = 4'd10;
   localparam logic [3:0] S_DNWR  = 4'd11;
   localparam logic [3:0] S_DONE  = 4'd12;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [6:0]    limit_ff, limit_in;
   logic [CW-1:0] idx_ff, idx_in;     // current record
   logic [CW-1:0] hit_ff, hit_in;     // matched record
   logic [CW-1:0] drop_ff, drop_in;   // record being removed
   logic          op_ff, op_in;
   logic [SW-1:0] need_ff, need_in;
   logic [SW-1:0] key_ff, key_in;
   logic [SW-1:0] acc_ff, acc_in;     // merged size of hit record
   logic [SW-1:0] haddr_ff, haddr_in;
   logic          merged_ff, merged_in; // next already merged
   rsp_type       rsp_ff, rsp_in;
   logic          rspv_ff, rspv_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [DW-1:0] wr_data, rd_data;
   logic          r_free;
   logic [SW-1:0] r_addr, r_size;
   logic [SW:0]   need_sum;
   logic [CW-1:0] cap;

   ffba_table #(.DEPTH(MAX_RECORDS), .AW(AW), .DW(DW)) u_table (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   assign {r_free, r_addr, r_size} = rd_data;
   assign need_sum = {1'b0, req_item.request_size} + (SW+1)'(GRANULE - 1);
   assign cap = (32'(limit_ff) > MAX_RECORDS) ? CW'(MAX_RECORDS) : CW'(limit_ff);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE) && !start;
   assign rsp_valid = rspv_ff;
   assign rsp_item  = rsp_ff;

   // sequencer
   always_comb begin
      state_in = state_ff; count_in = count_ff; limit_in = limit_ff;
      idx_in = idx_ff; hit_in = hit_ff; drop_in = drop_ff; op_in = op_ff;
      need_in = need_ff; key_in = key_ff; acc_in = acc_ff;
      haddr_in = haddr_ff; merged_in = merged_ff;
      rsp_in = rsp_ff; rspv_in = 1'b0;
      wr_en = 1'b0; wr_addr = '0; wr_data = '0;
      rd_addr = idx_ff[AW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (csr_valid && csr_ready) begin
               limit_in = csr_data;
               if (csr_data == 7'd0) begin
                  count_in = '0;
               end else begin
                  count_in = CW'(1);
                  wr_en = 1'b1;
                  wr_data = {1'b1, SW'(ALLOC_BASE), SW'(RAM_BYTES - ALLOC_BASE)};
               end
            end else if (start) begin
               op_in = req_item.opcode;
               need_in = {need_sum[SW:4], 4'b0} == '0 ? SW'(GRANULE)
                                                      : {need_sum[SW-1:4], 4'b0};
               if (need_sum[SW]) need_in = {1'b1, {(SW-1){1'b0}}};
               key_in = {2'b0, req_item.block_addr};
               idx_in = '0;
               merged_in = 1'b0;
               if (limit_ff == 7'd0) begin
                  rsp_in = '{granted_addr: '0, status: ST_NOTABLE};
                  state_in = S_DONE;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            if (idx_ff >= count_ff) begin
               rsp_in = '{granted_addr: '0,
                          status: (op_ff == OP_ALLOC) ? ST_NOMEM : ST_UNKNOWN};
               state_in = S_DONE;
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_RD;
            idx_in = idx_ff + CW'(1);
            hit_in = idx_ff;
            haddr_in = r_addr;
            if (op_ff == OP_ALLOC) begin
               if (r_free && r_size >= need_ff) begin
                  if (r_size == need_ff) begin
                     wr_en = 1'b1; wr_addr = idx_ff[AW-1:0];
                     wr_data = {1'b0, r_addr, r_size};
                     rsp_in = '{granted_addr: r_addr[18:0], status: ST_OK};
                     state_in = S_DONE;
                  end else if (count_ff >= cap) begin
                     rsp_in = '{granted_addr: '0, status: ST_FULL};
                     state_in = S_DONE;
                  end else begin
                     acc_in = r_size - need_ff;
                     idx_in = count_ff;
                     state_in = S_UPRD;
                  end
               end
            end else if (!r_free && r_addr == key_ff) begin
               acc_in = r_size;
               wr_en = 1'b1; wr_addr = idx_ff[AW-1:0];
               wr_data = {1'b1, r_addr, r_size};
               idx_in = idx_ff + CW'(1);
               state_in = S_NXRD;
            end
         end
         // shift tail up one record, from the end down to hit+1
         S_UPRD: begin
            if (idx_ff == hit_ff + CW'(1)) begin
               state_in = S_SPLIT;
            end else begin
               rd_addr = AW'(idx_ff - CW'(1));
               state_in = S_UPWR;
            end
         end
         S_UPWR: begin
            wr_en = 1'b1; wr_addr = idx_ff[AW-1:0]; wr_data = rd_data;
            idx_in = idx_ff - CW'(1);
            state_in = S_UPRD;
         end
         S_SPLIT: begin
            wr_en = 1'b1; wr_addr = AW'(hit_ff + CW'(1));
            wr_data = {1'b1, haddr_ff + need_ff, acc_ff};
            count_in = count_ff + CW'(1);
            state_in = S_DONE;
            rsp_in = '{granted_addr: haddr_ff[18:0], status: ST_OK};
         end
         // free: look at the next record for a merge
         S_NXRD: begin
            if (idx_ff >= count_ff) begin
               state_in = S_PVRD;
            end else begin
               state_in = S_NXCK;
            end
         end
         S_NXCK: begin
            state_in = S_PVRD;
            if (r_free) begin
               acc_in = acc_ff + r_size;
               wr_en = 1'b1; wr_addr = hit_ff[AW-1:0];
               wr_data = {1'b1, haddr_ff, acc_ff + r_size};
               drop_in = idx_ff;
               merged_in = 1'b1;
               idx_in = idx_ff;
               state_in = S_DNRD;
            end
         end
         S_PVRD: begin
            if (hit_ff == '0) begin
               rsp_in = '{granted_addr: '0, status: ST_OK};
               state_in = S_DONE;
            end else begin
               rd_addr = AW'(hit_ff - CW'(1));
               state_in = S_PVCK;
            end
         end
         S_PVCK: begin
            rsp_in = '{granted_addr: '0, status: ST_OK};
            state_in = S_DONE;
            if (r_free) begin
               wr_en = 1'b1; wr_addr = AW'(hit_ff - CW'(1));
               wr_data = {1'b1, r_addr, r_size + acc_ff};
               drop_in = hit_ff;
               idx_in = hit_ff;
               merged_in = 1'b0;
               hit_in = '0;
               state_in = S_DNRD;
            end
         end
         // remove record drop: shift tail down one record
         S_DNRD: begin
            if (idx_ff + CW'(1) >= count_ff) begin
               count_in = count_ff - CW'(1);
               if (merged_ff) begin
                  merged_in = 1'b0;
                  state_in = S_PVRD;
               end else begin
                  rsp_in = '{granted_addr: '0, status: ST_OK};
                  state_in = S_DONE;
               end
            end else begin
               rd_addr = AW'(idx_ff + CW'(1));
               state_in = S_DNWR;
            end
         end
         S_DNWR: begin
            wr_en = 1'b1; wr_addr = idx_ff[AW-1:0]; wr_data = rd_data;
            idx_in = idx_ff + CW'(1);
            state_in = S_DNRD;
         end
         S_DONE: begin
            rspv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // split head rewritten as used once the tail shift is done
      if (state_ff == S_UPRD && idx_ff == hit_ff + CW'(1)) begin
         wr_en = 1'b1; wr_addr = hit_ff[AW-1:0];
         wr_data = {1'b0, haddr_ff, need_ff};
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         limit_ff <= '0;
         rspv_ff  <= 1'b0;
         merged_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         limit_ff <= limit_in;
         rspv_ff  <= rspv_in;
         merged_ff <= merged_in;
      end
      idx_ff <= idx_in; hit_ff <= hit_in; drop_ff <= drop_in; op_ff <= op_in;
      need_ff <= need_in; key_ff <= key_in; acc_ff <= acc_in;
      haddr_ff <= haddr_in; rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rspv_ff |-> state_ff == S_IDLE) else $error("strobe while busy");
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_RECORDS)) else $error("count over capacity");
   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rspv_ff |=> !rspv_ff) else $error("double strobe");
   a_drop_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DNWR |-> drop_ff <= idx_ff) else $error("bad drop index");
`endif
endmodule

// ===== sim/first_fit_block_allocator_top_tb.sv =====
`timescale 1ns / 1ps
module first_fit_block_allocator_top_tb;
   import ffba_pkg::*;

   localparam int RAM_SIZE  = 524288;
   localparam int REC_MAX   = 64;
   localparam int RAND_ITEMS = 2000;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef struct {
      bit          is_free;
      int unsigned base;
      int unsigned span;
   } block_rec_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [6:0] csr_data = '0;

   // allocator shadow state
   block_rec_type blocks[$];
   int unsigned limit_shadow = 0;
   rsp_type     grant_queue[$];
   int unsigned fail_count = 0;
   longint      cycle_count = 0;
   int unsigned live_addrs[$];

   first_fit_block_allocator_top DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // rebuild table on limit write
   function automatic void rebuild_table(input int unsigned lim);
      limit_shadow = lim;
      blocks.delete();
      if (lim != 0) blocks.push_back('{1'b1, ALLOC_BASE, RAM_SIZE - ALLOC_BASE});
   endfunction

   // predict result of one item and update the table
   function automatic rsp_type alloc_outcome(input req_type it);
      rsp_type r;
      int unsigned need, cap;
      block_rec_type nb;
      r = '0;
      cap = (limit_shadow > REC_MAX) ? REC_MAX : limit_shadow;
      if (limit_shadow == 0) begin
         r.status = ST_NOTABLE;
         return r;
      end
      if (it.opcode == OP_ALLOC) begin
         need = (int'(it.request_size) + 15) & ~32'd15;
         if (need == 0) need = GRANULE;
         r.status = ST_NOMEM;
         for (int i = 0; i < blocks.size(); i++) begin
            if (!blocks[i].is_free || blocks[i].span < need) continue;
            if (blocks[i].span == need) begin
               blocks[i].is_free = 1'b0;
               r.status = ST_OK;
               r.granted_addr = blocks[i].base[18:0];
            end else if (blocks.size() >= cap) begin
               r.status = ST_FULL;
            end else begin
               nb = '{1'b1, blocks[i].base + need, blocks[i].span - need};
               blocks[i].is_free = 1'b0;
               blocks[i].span = need;
               blocks.insert(i + 1, nb);
               r.status = ST_OK;
               r.granted_addr = blocks[i].base[18:0];
            end
            break;
         end
      end else begin
         r.status = ST_UNKNOWN;
         for (int i = 0; i < blocks.size(); i++) begin
            if (blocks[i].is_free || blocks[i].base != it.block_addr) continue;
            blocks[i].is_free = 1'b1;
            if (i + 1 < blocks.size() && blocks[i+1].is_free) begin
               blocks[i].span += blocks[i+1].span;
               blocks.delete(i + 1);
            end
            if (i > 0 && blocks[i-1].is_free) begin
               blocks[i-1].span += blocks[i].span;
               blocks.delete(i);
            end
            r.status = ST_OK;
            break;
         end
      end
      return r;
   endfunction

   // compare each result with oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (grant_queue.size() == 0) begin
            $error("result with nothing expected: addr %0h status %0d",
                   rsp_item.granted_addr, rsp_item.status);
            fail_count++;
         end else begin
            if (rsp_item.status !== grant_queue[0].status) begin
               $error("status: expected %0d actual %0d", grant_queue[0].status,
                      rsp_item.status);
               fail_count++;
            end
            if (rsp_item.granted_addr !== grant_queue[0].granted_addr) begin
               $error("granted_addr: expected %0h actual %0h",
                      grant_queue[0].granted_addr, rsp_item.granted_addr);
               fail_count++;
            end
            if (rsp_item.status == ST_OK && rsp_item.granted_addr != 0)
               live_addrs.push_back(rsp_item.granted_addr);
            void'(grant_queue.pop_front());
         end
      end
   end

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
      repeat (n) @(negedge clock);
   endtask

   // send one item; chk holds a typed expectation when use_typed is set
   task automatic send_item(input req_type it, input bit use_typed, input rsp_type chk);
      rsp_type p;
      @(negedge clock);
      while (busy) @(negedge clock);
      p = alloc_outcome(it);
      if (use_typed) begin
         if (p.status != chk.status) begin
            $error("status: expected %0d actual %0d (predictor)", chk.status, p.status);
            fail_count++;
         end
         if (p.granted_addr != chk.granted_addr) begin
            $error("granted_addr: expected %0h actual %0h (predictor)",
                   chk.granted_addr, p.granted_addr);
            fail_count++;
         end
         grant_queue.push_back(chk);
      end else begin
         grant_queue.push_back(p);
      end
      req_item <= it;
      start <= 1'b1;
      @(posedge clock);
      @(negedge clock);
      start <= 1'b0;
      if ($urandom_range(0, 3) != 0) idle_gap();
   endtask

   task automatic drain();
      while (grant_queue.size() != 0 || busy) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_limit(input int unsigned lim);
      drain();
      csr_data <= lim[6:0];
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      rebuild_table(lim);
      live_addrs.delete();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type mk(input logic op, input int unsigned sz,
                                  input int unsigned ad);
      req_type t;
      t.opcode = op;
      t.request_size = sz[19:0];
      t.block_addr = ad[18:0];
      return t;
   endfunction

   function automatic rsp_type rs(input int unsigned ad, input logic [2:0] st);
      rsp_type t;
      t.granted_addr = ad[18:0];
      t.status = st;
      return t;
   endfunction

   typedef struct {
      int          limit_before;  // -1 keeps current limit
      req_type     it;
      bit          typed;
      rsp_type     chk;
   } stim_row_type;

   stim_row_type script[$];

   initial begin
      int unsigned lims[6];
      req_type it;
      int k, pick;
      lims = '{1, 2, 3, 64, 127, 8};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows
      script.push_back('{-1, mk(OP_ALLOC, 16, 0), 1, rs(0, ST_NOTABLE)});
      script.push_back('{-1, mk(OP_FREE, 0, 19'h7FFFF), 1, rs(0, ST_NOTABLE)});
      script.push_back('{2, mk(OP_ALLOC, 0, 0), 1, rs(ALLOC_BASE, ST_OK)});
      script.push_back('{-1, mk(OP_ALLOC, 1, 0), 1, rs(0, ST_FULL)});
      script.push_back('{-1, mk(OP_ALLOC, 20'hFFFFF, 0), 1, rs(0, ST_NOMEM)});
      script.push_back('{-1, mk(OP_FREE, 0, 0), 1, rs(0, ST_UNKNOWN)});
      script.push_back('{-1, mk(OP_FREE, 0, ALLOC_BASE + 16), 1, rs(0, ST_UNKNOWN)});
      script.push_back('{-1, mk(OP_FREE, 0, ALLOC_BASE), 1, rs(0, ST_OK)});
      script.push_back('{1, mk(OP_ALLOC, RAM_SIZE - ALLOC_BASE, 0), 1,
                         rs(ALLOC_BASE, ST_OK)});
      script.push_back('{-1, mk(OP_ALLOC, 16, 0), 1, rs(0, ST_NOMEM)});
      script.push_back('{127, mk(OP_ALLOC, 17, 0), 1, rs(ALLOC_BASE, ST_OK)});
      script.push_back('{-1, mk(OP_ALLOC, 32, 0), 0, rs(0, 0)});
      script.push_back('{-1, mk(OP_ALLOC, 48, 0), 0, rs(0, 0)});
      script.push_back('{-1, mk(OP_FREE, 0, ALLOC_BASE + 32), 0, rs(0, 0)});
      script.push_back('{-1, mk(OP_FREE, 0, ALLOC_BASE), 0, rs(0, 0)});
      script.push_back('{-1, mk(OP_FREE, 0, ALLOC_BASE + 64), 0, rs(0, 0)});
      script.push_back('{-1, mk(OP_ALLOC, RAM_SIZE, 0), 1, rs(0, ST_NOMEM)});
      script.push_back('{-1, mk(OP_ALLOC, 20'hAAAAA, 19'h55555), 1, rs(0, ST_NOMEM)});
      script.push_back('{0, mk(OP_FREE, 20'hFFFFF, 19'h2AAAA), 1, rs(0, ST_NOTABLE)});
      foreach (script[i]) begin
         if (script[i].limit_before >= 0) write_limit(script[i].limit_before);
         send_item(script[i].it, script[i].typed, script[i].chk);
      end

      // random phases over several limits
      k = 0;
      foreach (lims[p]) begin
         write_limit(lims[p]);
         for (int j = 0; j < RAND_ITEMS / 6; j++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               if ($urandom_range(0, 3) == 0)
                  it = mk(OP_ALLOC, $urandom_range(0, 20'hFFFFF), $urandom);
               else
                  it = mk(OP_ALLOC, $urandom_range(0, 4096), $urandom);
            end else if (pick < 85 && live_addrs.size() != 0) begin
               k = $urandom_range(0, live_addrs.size() - 1);
               it = mk(OP_FREE, $urandom, live_addrs[k]);
               live_addrs.delete(k);
            end else begin
               it = mk(1'($urandom_range(0, 1)), $urandom, $urandom);
            end
            send_item(it, 1'b0, rs(0, 0));
         end
      end

      drain();
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
